>>> rtl/bracketed_command_parser_assert.svh
// Assertion macros for the parser top level; empty under synthesis.
`ifndef BRACKETED_COMMAND_PARSER_ASSERT_SVH
`define BRACKETED_COMMAND_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define BCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcp: same-cycle check failed");
// Next-cycle implication.
`define BCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcp: next-cycle check failed");
`else
`define BCP_ASSERT_IMP(lbl, ante, cons)
`define BCP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/bcp_pkg.sv
// Shared constants and types of the bracketed command parser.
package bcp_pkg;

    localparam int FRAME_BYTES     = 256;
    localparam int MAX_TOKEN_COUNT = 10;
    localparam int TOKEN_CHARS     = 31;

    localparam int FILL_W = $clog2(FRAME_BYTES);
    localparam int TIDX_W = $clog2(MAX_TOKEN_COUNT + 1);
    localparam int SPAN_W = $clog2(TOKEN_CHARS + 1);
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    localparam int VAL_W      = 16;
    localparam int OUT_DATA_W = 72;

    localparam int KW_COUNT    = 8;
    localparam int KW_JOYSTICK = 0;
    localparam int KW_J        = 1;
    localparam int KW_SLIDER   = 2;
    localparam int KW_S        = 3;
    localparam int KW_KEY      = 4;
    localparam int KW_K        = 5;
    localparam int KW_DOWN     = 6;
    localparam int KW_D        = 7;

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"j", "o", "y", "s", "t", "i", "c", "k"},
        '{"j", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "l", "i", "d", "e", "r", 8'h00, 8'h00},
        '{"s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"k", "e", "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"k", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", "w", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [CNT_W-1:0] KW_LEN [KW_COUNT] = '{
        5'd8, 5'd1, 5'd6, 5'd1, 5'd3, 5'd1, 5'd4, 5'd1
    };

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    // command kinds and record kinds
    localparam logic [1:0] KIND_JOYSTICK = 2'd0;
    localparam logic [1:0] KIND_SLIDER   = 2'd1;
    localparam logic [1:0] KIND_KEY      = 2'd2;
    localparam logic [1:0] KIND_CLEARED  = 2'd3;
    localparam logic [1:0] CMD_UNKNOWN   = 2'd3;

    localparam int JOY_TOKENS  = 5;
    localparam int PAIR_TOKENS = 3;

    // number reader phases
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic              started;
        logic              pending;
        logic              ended;
        logic [SPAN_W-1:0] span;
        logic [CNT_W-1:0]  count;
        logic [KW_COUNT-1:0] flags;
        logic [VAL_W-1:0]  acc;
        logic              neg;
        logic [1:0]        phase;
    } t_tok_state;

    typedef struct packed {
        logic             started;
        logic [1:0]       cmd;
        logic [VAL_W-1:0] value;
        logic             key_down;
    } t_tok_end;

    localparam t_tok_state TOK_CLEAR = '{
        started: 1'b0, pending: 1'b0, ended: 1'b0, span: '0, count: '0,
        flags: '1, acc: '0, neg: 1'b0, phase: PH_LEAD
    };

endpackage

>>> rtl/bcp_token_unit.sv
// Per-character token update: trimming, keyword match and running atoi.
module bcp_token_unit
    import bcp_pkg::*;
(
    input  t_tok_state i_tok,
    input  logic [7:0] i_byte,
    input  logic       i_body,
    input  logic       i_clear,
    output t_tok_state o_tok,
    output t_tok_end   o_end
);

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic t_tok_state feed_char(t_tok_state s, logic [7:0] c);
        t_tok_state       r;
        logic [7:0]       lc;
        logic             digit;
        logic [VAL_W-1:0] dval;
        r     = s;
        lc    = c;
        digit = (c >= "0") && (c <= "9");
        dval  = {8'd0, 8'(c - 8'h30)};
        if (!s.ended) begin
            if (c == CH_NUL) begin
                r.ended = 1'b1;
            end else begin
                if (c >= "A" && c <= "Z") begin
                    lc = 8'(c + 8'd32);
                end
                for (int i = 0; i < KW_COUNT; i++) begin
                    if (s.flags[i] && (s.count >= KW_LEN[i] ||
                                       KW_TEXT[i][s.count[2:0]] != lc)) begin
                        r.flags[i] = 1'b0;
                    end
                end
                if (s.count < COUNT_MAX) begin
                    r.count = s.count + CNT_W'(1);
                end
                case (s.phase)
                    PH_LEAD: begin
                        if (is_ws(c)) begin
                            r.phase = PH_LEAD;
                        end else if (c == "+" || c == "-") begin
                            r.phase = PH_SIGN;
                            if (c == "-") begin
                                r.neg = 1'b1;
                            end
                        end else if (digit) begin
                            r.acc   = dval;
                            r.phase = PH_DIGITS;
                        end else begin
                            r.phase = PH_DONE;
                        end
                    end
                    PH_SIGN: begin
                        if (digit) begin
                            r.acc   = dval;
                            r.phase = PH_DIGITS;
                        end else begin
                            r.phase = PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        if (digit) begin
                            r.acc = (s.acc << 3) + (s.acc << 1) + dval;
                        end else begin
                            r.phase = PH_DONE;
                        end
                    end
                    default: begin
                        r.phase = s.phase;
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic logic kw_hit(t_tok_state s, int i);
        return s.flags[i] && (s.count == KW_LEN[i]);
    endfunction

    t_tok_state w_body;

    // body character: trim spaces, keep at most TOKEN_CHARS of the span
    always_comb begin
        w_body = i_tok;
        if (i_byte == CH_SPACE) begin
            if (i_tok.started && i_tok.span < SPAN_W'(TOKEN_CHARS)) begin
                w_body.pending = 1'b1;
                w_body.span    = i_tok.span + SPAN_W'(1);
            end
        end else begin
            w_body.started = 1'b1;
            if (i_tok.pending) begin
                w_body         = feed_char(w_body, CH_SPACE);
                w_body.pending = 1'b0;
            end
            if (i_tok.span < SPAN_W'(TOKEN_CHARS)) begin
                w_body      = feed_char(w_body, i_byte);
                w_body.span = i_tok.span + SPAN_W'(1);
            end
        end
    end

    always_comb begin
        if (i_clear) begin
            o_tok = TOK_CLEAR;
        end else if (i_body) begin
            o_tok = w_body;
        end else begin
            o_tok = i_tok;
        end
    end

    // what the current token yields when a comma or ']' closes it
    always_comb begin
        o_end.started  = i_tok.started;
        o_end.value    = i_tok.neg ? VAL_W'(-i_tok.acc) : i_tok.acc;
        o_end.key_down = kw_hit(i_tok, KW_DOWN) || kw_hit(i_tok, KW_D);
        if (kw_hit(i_tok, KW_JOYSTICK) || kw_hit(i_tok, KW_J)) begin
            o_end.cmd = KIND_JOYSTICK;
        end else if (kw_hit(i_tok, KW_SLIDER) || kw_hit(i_tok, KW_S)) begin
            o_end.cmd = KIND_SLIDER;
        end else if (kw_hit(i_tok, KW_KEY) || kw_hit(i_tok, KW_K)) begin
            o_end.cmd = KIND_KEY;
        end else begin
            o_end.cmd = CMD_UNKNOWN;
        end
    end

endmodule

>>> rtl/bracketed_command_parser.sv
// Top level of the bracketed command parser: stream ports, frame state, record output.
// An accepted item passes through the input register, then the record register that drives o_m_tvalid.
// Throughput: one item per cycle; while a record waits on i_m_tready, hold the next item
//   in the input register and stall intake until the record is taken.
// Per-item work is one pass of the token unit plus the frame/record update logic.
// Reset (i_rst_n low, synchronous) empties both registers and clears all parser state.
`include "bracketed_command_parser_assert.svh"
module bracketed_command_parser
    import bcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,  // [7:0] data_byte
    input  logic [0:0]            i_s_tuser,  // [0] operation
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // [15:0] first_value, [31:16] second_value,
                                              // [47:32] third_value, [63:48] fourth_value,
                                              // [64] key_pressed, [71:65] zero
    output logic [1:0]            o_m_tuser   // [1:0] record_kind
);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // parser state
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [TIDX_W-1:0] r_tidx, n_tidx;
    logic [1:0]        r_cmd, n_cmd;
    logic [VAL_W-1:0]  r_held [4];
    logic [VAL_W-1:0]  n_held [4];
    logic              r_key, n_key;
    t_tok_state        r_tok, n_tok;

    // record register
    logic             r_out_valid;
    logic [1:0]       r_out_kind, n_out_kind;
    logic [VAL_W-1:0] r_out_v [4];
    logic [VAL_W-1:0] n_out_v [4];
    logic             r_out_key, n_out_key;
    logic             n_emit;

    logic       w_adv;
    logic       w_tok_body;
    logic       w_tok_clear;
    t_tok_end   w_end;

    // state after closing the current token
    logic [TIDX_W-1:0] e_tidx;
    logic [1:0]        e_cmd;
    logic [VAL_W-1:0]  e_held [4];
    logic              e_key;

    // advance the item in the input register whenever the record slot frees up
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    bcp_token_unit u_token (
        .i_tok   (r_tok),
        .i_byte  (r_in_byte),
        .i_body  (w_tok_body),
        .i_clear (w_tok_clear),
        .o_tok   (n_tok),
        .o_end   (w_end)
    );

    // close a token: the first names the command, tokens 1..4 hold values
    always_comb begin
        e_tidx = r_tidx;
        e_cmd  = r_cmd;
        e_held = r_held;
        e_key  = r_key;
        if (w_end.started && r_tidx < TIDX_W'(MAX_TOKEN_COUNT)) begin
            if (r_tidx == '0) begin
                e_cmd = w_end.cmd;
            end
            for (int j = 0; j < 4; j++) begin
                if (r_tidx == TIDX_W'(j + 1)) begin
                    e_held[j] = w_end.value;
                end
            end
            if (r_tidx == TIDX_W'(2)) begin
                e_key = w_end.key_down;
            end
            e_tidx = r_tidx + TIDX_W'(1);
        end
    end

    // frame control and record building
    always_comb begin
        n_fill      = r_fill;
        n_tidx      = r_tidx;
        n_cmd       = r_cmd;
        n_held      = r_held;
        n_key       = r_key;
        w_tok_body  = 1'b0;
        w_tok_clear = 1'b0;
        n_emit      = 1'b0;
        n_out_kind  = KIND_CLEARED;
        n_out_v     = '{default: '0};
        n_out_key   = 1'b0;
        if (r_in_op) begin
            // link dropped: clear everything, report it
            n_fill      = '0;
            n_tidx      = '0;
            n_cmd       = KIND_JOYSTICK;
            n_held      = '{default: '0};
            n_key       = 1'b0;
            w_tok_clear = 1'b1;
            n_emit      = 1'b1;
        end else if (r_in_byte == CH_LBRACKET) begin
            // restart the frame
            n_fill      = FILL_W'(1);
            n_tidx      = '0;
            n_cmd       = KIND_JOYSTICK;
            n_held      = '{default: '0};
            n_key       = 1'b0;
            w_tok_clear = 1'b1;
        end else if (r_fill != '0 && r_fill < FILL_W'(FRAME_BYTES - 1)) begin
            n_fill = r_fill + FILL_W'(1);
            if (r_in_byte == CH_COMMA) begin
                n_tidx      = e_tidx;
                n_cmd       = e_cmd;
                n_held      = e_held;
                n_key       = e_key;
                w_tok_clear = 1'b1;
            end else if (r_in_byte != CH_RBRACKET) begin
                w_tok_body = 1'b1;
            end else begin
                // end of frame: emit if the command is known and complete
                n_fill      = '0;
                n_tidx      = '0;
                n_cmd       = KIND_JOYSTICK;
                n_held      = '{default: '0};
                n_key       = 1'b0;
                w_tok_clear = 1'b1;
                if (e_cmd == KIND_JOYSTICK && e_tidx >= TIDX_W'(JOY_TOKENS)) begin
                    n_emit     = 1'b1;
                    n_out_kind = KIND_JOYSTICK;
                    n_out_v    = e_held;
                end else if (e_cmd == KIND_SLIDER && e_tidx >= TIDX_W'(PAIR_TOKENS)) begin
                    n_emit     = 1'b1;
                    n_out_kind = KIND_SLIDER;
                    n_out_v[0] = e_held[0];
                    n_out_v[1] = e_held[1];
                end else if (e_cmd == KIND_KEY && e_tidx >= TIDX_W'(PAIR_TOKENS)) begin
                    n_emit     = 1'b1;
                    n_out_kind = KIND_KEY;
                    n_out_v[0] = e_held[0];
                    n_out_key  = e_key;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_tidx      <= '0;
            r_cmd       <= KIND_JOYSTICK;
            r_held      <= '{default: '0};
            r_key       <= 1'b0;
            r_tok       <= TOK_CLEAR;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= n_emit;
                r_fill      <= n_fill;
                r_tidx      <= n_tidx;
                r_cmd       <= n_cmd;
                r_held      <= n_held;
                r_key       <= n_key;
                r_tok       <= n_tok;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_op   <= i_s_tuser[0];
            r_in_byte <= i_s_tdata;
        end
        if (w_adv && n_emit) begin
            r_out_kind <= n_out_kind;
            r_out_v    <= n_out_v;
            r_out_key  <= n_out_key;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {7'd0, r_out_key, r_out_v[3], r_out_v[2], r_out_v[1], r_out_v[0]};

    `BCP_ASSERT_IMP(a_tidx_bound, 1'b1, r_tidx <= TIDX_W'(MAX_TOKEN_COUNT))
    `BCP_ASSERT_NXT(a_disc_clears, w_adv && r_in_op, r_fill == '0 && r_tidx == '0)
    `BCP_ASSERT_IMP(a_cleared_zero, r_out_valid && r_out_kind == KIND_CLEARED,
        r_out_v[0] == '0 && r_out_v[1] == '0 && r_out_v[2] == '0 && r_out_v[3] == '0 &&
        !r_out_key)
    `BCP_ASSERT_IMP(a_stall_blocks, r_in_valid && r_out_valid && !i_m_tready, !o_s_tready)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bracketed command parser: directed frames, then random traffic.
module testbench;
    import bcp_pkg::*;

    // item kinds carried on i_s_tuser
    localparam logic OP_BYTE       = 1'b0;
    localparam logic OP_DISCONNECT = 1'b1;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'd32;

    localparam int VALUE_SLOTS     = 4;
    localparam int RANDOM_ITEMS    = 1300;
    localparam int MIN_RECORDS     = 40;
    localparam int OVERSIZE_FRAME  = 30;
    localparam int HOLD_OFF_AFTER  = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] first_value;
        logic [VAL_W-1:0] second_value;
        logic [VAL_W-1:0] third_value;
        logic [VAL_W-1:0] fourth_value;
        logic             key_pressed;
    } t_parser_record;

    typedef struct {
        logic           op;
        logic [7:0]     data;
        bit             typed;
        t_parser_record want;
    } t_stimulus_row;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;  // [7:0] data_byte
    logic [0:0]            i_s_tuser  = '0;  // [0] operation
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // [15:0] first .. [63:48] fourth, [64] key_pressed
    logic [1:0]            o_m_tuser;        // [1:0] record_kind

    bracketed_command_parser u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser mirror: frame, token and number-reader state
    // ------------------------------------------------------------------
    string keyword_text [KW_COUNT] = '{"joystick", "j", "slider", "s", "key", "k", "down", "d"};

    int unsigned      frame_fill;
    int unsigned      tokens_done;
    logic [CNT_W-1:0] kept_len;
    logic [7:0]       word_hits;
    logic [1:0]       cmd_kind;
    logic [VAL_W-1:0] num_acc;
    logic [1:0]       num_phase;
    logic             num_neg;
    logic [VAL_W-1:0] field_vals [VALUE_SLOTS];
    logic             key_down;
    logic             tok_started;
    logic             tok_pending;
    logic             tok_ended;
    int unsigned      tok_span;

    t_parser_record expected_records [$];
    int             fail_count        = 0;
    int             records_seen      = 0;
    int             records_predicted = 0;
    int             items_taken       = 0;
    int             cycle_count       = 0;

    function automatic void clear_token();
        tok_started = 1'b0;
        tok_pending = 1'b0;
        tok_ended   = 1'b0;
        tok_span    = 0;
        kept_len    = '0;
        word_hits   = '1;
        num_acc     = '0;
        num_phase   = PH_LEAD;
        num_neg     = 1'b0;
    endfunction

    function automatic void clear_frame();
        tokens_done = 0;
        cmd_kind    = KIND_JOYSTICK;
        key_down    = 1'b0;
        foreach (field_vals[i]) field_vals[i] = '0;
        clear_token();
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // One character of the trimmed token: keyword match and atoi-style number reading.
    function automatic void take_char(logic [7:0] c);
        logic [7:0] lc;
        bit         digit;
        int         i;
        if (tok_ended) return;
        if (c == CH_NUL) begin
            tok_ended = 1'b1;
            return;
        end
        lc    = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
        digit = c >= CH_ZERO && c <= CH_NINE;
        for (i = 0; i < KW_COUNT; i++) begin
            if (word_hits[i] && (kept_len >= keyword_text[i].len() ||
                                 keyword_text[i][kept_len] != lc))
                word_hits[i] = 1'b0;
        end
        if (kept_len < COUNT_MAX) kept_len++;
        case (num_phase)
            PH_LEAD: begin
                if (!is_blank(c)) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        num_phase = PH_SIGN;
                        num_neg   = (c == CH_MINUS);
                    end else if (digit) begin
                        num_acc   = 16'(c - CH_ZERO);
                        num_phase = PH_DIGITS;
                    end else begin
                        num_phase = PH_DONE;
                    end
                end
            end
            PH_SIGN: begin
                if (digit) begin
                    num_acc   = 16'(c - CH_ZERO);
                    num_phase = PH_DIGITS;
                end else begin
                    num_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (digit) num_acc = num_acc * 16'd10 + 16'(c - CH_ZERO);
                else num_phase = PH_DONE;
            end
            default: begin
            end
        endcase
    endfunction

    // Trim leading spaces; hold an interior run of spaces until a later character shows up.
    function automatic void body_char(logic [7:0] c);
        if (c == CH_SPACE) begin
            if (!tok_started) return;
            if (tok_span < TOKEN_CHARS) tok_pending = 1'b1;
        end else begin
            tok_started = 1'b1;
            if (tok_pending) begin
                take_char(CH_SPACE);
                tok_pending = 1'b0;
            end
            if (tok_span < TOKEN_CHARS) take_char(c);
        end
        if (tok_span < TOKEN_CHARS) tok_span++;
    endfunction

    function automatic bit word_hit(int idx);
        return word_hits[idx] && kept_len == keyword_text[idx].len();
    endfunction

    function automatic void finish_token();
        logic [VAL_W-1:0] v;
        if (tok_started && tokens_done < MAX_TOKEN_COUNT) begin
            if (tokens_done == 0) begin
                if (word_hit(KW_JOYSTICK) || word_hit(KW_J)) cmd_kind = KIND_JOYSTICK;
                else if (word_hit(KW_SLIDER) || word_hit(KW_S)) cmd_kind = KIND_SLIDER;
                else if (word_hit(KW_KEY) || word_hit(KW_K)) cmd_kind = KIND_KEY;
                else cmd_kind = CMD_UNKNOWN;
            end else if (tokens_done <= VALUE_SLOTS) begin
                v = num_neg ? -num_acc : num_acc;
                field_vals[tokens_done - 1] = v;
                if (tokens_done == 2) key_down = word_hit(KW_DOWN) || word_hit(KW_D);
            end
            tokens_done++;
        end
        clear_token();
    endfunction

    // Advance the mirror by one accepted item; return 1 when it yields a record.
    function automatic bit parse_item(input logic op, input logic [7:0] c,
                                      output t_parser_record rec);
        bit emits;
        rec = '0;
        if (op == OP_DISCONNECT) begin
            frame_fill = 0;
            clear_frame();
            rec.kind = KIND_CLEARED;
            return 1'b1;
        end
        if (c == CH_LBRACKET) begin
            frame_fill = 1;
            clear_frame();
            return 1'b0;
        end
        if (frame_fill == 0 || frame_fill >= FRAME_BYTES - 1) return 1'b0;
        frame_fill++;
        if (c != CH_RBRACKET) begin
            if (c == CH_COMMA) finish_token();
            else body_char(c);
            return 1'b0;
        end
        finish_token();
        frame_fill      = 0;
        emits           = 1'b1;
        rec.first_value = field_vals[0];
        if (cmd_kind == KIND_JOYSTICK && tokens_done >= JOY_TOKENS) begin
            rec.kind         = KIND_JOYSTICK;
            rec.second_value = field_vals[1];
            rec.third_value  = field_vals[2];
            rec.fourth_value = field_vals[3];
        end else if (cmd_kind == KIND_SLIDER && tokens_done >= PAIR_TOKENS) begin
            rec.kind         = KIND_SLIDER;
            rec.second_value = field_vals[1];
        end else if (cmd_kind == KIND_KEY && tokens_done >= PAIR_TOKENS) begin
            rec.kind        = KIND_KEY;
            rec.key_pressed = key_down;
        end else begin
            rec   = '0;
            emits = 1'b0;
        end
        clear_frame();
        return emits;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Offer one item, wait for the handshake, then predict and possibly idle.
    task automatic send_item(logic op, logic [7:0] c, bit typed, t_parser_record want,
                             bit steady);
        t_parser_record rec;
        bit             emits;
        int             gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        // bytes the parser drops outside a frame or past a full frame are not counted
        if (!(op == OP_BYTE && c != CH_LBRACKET &&
              (frame_fill == 0 || frame_fill >= FRAME_BYTES - 1)))
            items_taken++;
        emits = parse_item(op, c, rec);
        if (typed) expected_records.push_back(want);
        else if (emits) expected_records.push_back(rec);
        if (emits) records_predicted++;
        gap = steady ? 0 : idle_cycles();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    t_stimulus_row directed_rows [$];

    function automatic void add_row(logic op, logic [7:0] c, bit typed, t_parser_record want);
        t_stimulus_row row;
        row.op    = op;
        row.data  = c;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) add_row(OP_BYTE, s[i], 1'b0, '0);
    endfunction

    // Random traffic is built into this queue ({op, data}) and then sent.
    logic [8:0] outgoing [$];

    string command_words [12] = '{"joystick", "slider", "key", "j", "s", "k",
                                  "joystick", "slider", "key", "joy", "sliders", "k y"};
    string state_words [5] = '{"down", "d", "up", "dow", "downs"};

    function automatic void push_byte(logic [7:0] b);
        outgoing.push_back({OP_BYTE, b});
    endfunction

    function automatic void push_spaces(int n);
        repeat (n) push_byte(CH_SPACE);
    endfunction

    function automatic void push_digits(int n);
        repeat (n) push_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void push_sign();
        case ($urandom_range(0, 3))
            0: push_byte(CH_PLUS);
            1: push_byte(CH_MINUS);
            default: begin
            end
        endcase
    endfunction

    // Push a word with each letter in random case.
    function automatic void push_word(string w);
        logic [7:0] ch;
        int         i;
        for (i = 0; i < w.len(); i++) begin
            ch = w[i];
            if (ch >= CH_LOW_A && ch <= CH_LOW_Z && $urandom_range(0, 1) == 1) ch -= CASE_GAP;
            push_byte(ch);
        end
    endfunction

    // Printable character that neither opens, closes nor splits a frame.
    function automatic logic [7:0] text_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(8'h21, 8'h7E));
        while (ch == CH_LBRACKET || ch == CH_RBRACKET || ch == CH_COMMA);
        return ch;
    endfunction

    function automatic void value_token(bit state_slot);
        int pick;
        pick = (state_slot && $urandom_range(0, 9) < 6) ? 12 : $urandom_range(0, 15);
        if (pick <= 8) begin
            push_spaces($urandom_range(0, 2));
            push_sign();
            push_digits($urandom_range(1, 5));
            push_spaces($urandom_range(0, 2));
        end else begin
            case (pick)
                // enough digits to wrap past 16 bits
                9: begin
                    push_sign();
                    push_digits($urandom_range(6, 12));
                end
                // longer than the kept prefix, with interior spaces
                10: repeat ($urandom_range(TOKEN_CHARS + 1, TOKEN_CHARS + 14))
                    push_byte($urandom_range(0, 3) == 0 ? CH_SPACE
                                                        : 8'(CH_ZERO + $urandom_range(0, 9)));
                // empty or blank token, skipped by the parser
                11: push_spaces($urandom_range(0, 3));
                12: push_word(state_words[$urandom_range(0, 4)]);
                // zero byte cuts the token short
                13: begin
                    push_digits(2);
                    push_byte(CH_NUL);
                    push_byte(CH_SPACE);
                    push_digits(1);
                end
                // control whitespace ahead of the number
                14: begin
                    push_byte(8'(CH_TAB + $urandom_range(0, 4)));
                    push_sign();
                    push_digits($urandom_range(1, 4));
                end
                default: repeat ($urandom_range(1, 6)) push_byte(text_char());
            endcase
        end
    endfunction

    // Build one frame (mostly well formed), a noise burst, or a frame that overruns the limit.
    function automatic void build_traffic(bit oversize);
        int pick;
        int wanted;
        int n;
        int j;
        bit is_key;
        if (oversize) begin
            push_byte(CH_LBRACKET);
            push_word("j");
            repeat ($urandom_range(FRAME_BYTES, FRAME_BYTES + 16))
                push_byte($urandom_range(0, 7) == 0 ? CH_COMMA : text_char());
            push_byte(CH_RBRACKET);
            return;
        end
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 6) == 0) outgoing.push_back({OP_DISCONNECT, 8'($urandom)});
                else push_byte(8'($urandom));
            end
            return;
        end
        pick   = $urandom_range(0, 11);
        is_key = pick < 9 && pick % 3 == 2;
        if (pick < 9) wanted = (pick % 3 == 0) ? VALUE_SLOTS : PAIR_TOKENS - 1;
        else wanted = $urandom_range(0, VALUE_SLOTS);
        push_byte(CH_LBRACKET);
        push_spaces($urandom_range(0, 2));
        push_word(command_words[pick]);
        push_spaces($urandom_range(0, 2));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_TOKEN_COUNT + 2) : wanted;
        for (j = 1; j <= n; j++) begin
            push_byte(CH_COMMA);
            value_token(is_key && j == 2);
        end
        // mostly close the frame; sometimes abandon it or drop the link
        case ($urandom_range(0, 19))
            0: begin
            end
            1: outgoing.push_back({OP_DISCONNECT, 8'($urandom)});
            default: push_byte(CH_RBRACKET);
        endcase
    endfunction

    task automatic send_burst(bit steady);
        foreach (outgoing[k]) send_item(outgoing[k][8], outgoing[k][7:0], 1'b0, '0, steady);
        outgoing.delete();
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, one long hold-off, record checking
    // ------------------------------------------------------------------
    task automatic compare_record(t_parser_record got);
        t_parser_record want;
        if (expected_records.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected record: kind %0d values %0d %0d %0d %0d key %0b",
                         got.kind, $signed(got.first_value), $signed(got.second_value),
                         $signed(got.third_value), $signed(got.fourth_value), got.key_pressed);
            return;
        end
        want = expected_records.pop_front();
        if (got.kind !== want.kind || got.first_value !== want.first_value ||
            got.second_value !== want.second_value || got.third_value !== want.third_value ||
            got.fourth_value !== want.fourth_value || got.key_pressed !== want.key_pressed) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("record mismatch: expected kind %0d values %0d %0d %0d %0d key %0b",
                         want.kind, $signed(want.first_value), $signed(want.second_value),
                         $signed(want.third_value), $signed(want.fourth_value),
                         want.key_pressed);
                $display("                 actual   kind %0d values %0d %0d %0d %0d key %0b",
                         got.kind, $signed(got.first_value), $signed(got.second_value),
                         $signed(got.third_value), $signed(got.fourth_value), got.key_pressed);
            end
        end
    endtask

    int stall_left    = 0;
    int hold_off_left = 0;
    bit hold_off_done = 1'b0;

    always @(posedge i_clk) begin : record_monitor
        t_parser_record got;
        logic           ready_next;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind         = o_m_tuser;
            got.first_value  = o_m_tdata[VAL_W-1:0];
            got.second_value = o_m_tdata[2*VAL_W-1:VAL_W];
            got.third_value  = o_m_tdata[3*VAL_W-1:2*VAL_W];
            got.fourth_value = o_m_tdata[4*VAL_W-1:3*VAL_W];
            got.key_pressed  = o_m_tdata[4*VAL_W];
            compare_record(got);
            records_seen++;
        end
        // hold off once for a long stretch so the parser backs up into its input
        if (hold_off_left > 0) begin
            hold_off_left--;
            ready_next = 1'b0;
        end else if (!hold_off_done && records_seen >= HOLD_OFF_AFTER) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            ready_next    = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_cycles();
        end
        i_m_tready <= ready_next;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bracketed_command_parser test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        t_parser_record cleared_rec;
        t_parser_record key_rec;
        int             frames_built;
        frame_fill = 0;
        clear_frame();

        cleared_rec      = '0;
        cleared_rec.kind = KIND_CLEARED;
        key_rec             = '0;
        key_rec.kind        = KIND_KEY;
        key_rec.first_value = 16'd7;
        key_rec.key_pressed = 1'b1;

        // disconnect with an all-ones data byte, then a stray close outside any frame
        add_row(OP_DISCONNECT, 8'hFF, 1'b1, cleared_rec);
        add_row(OP_BYTE, CH_RBRACKET, 1'b0, '0);
        // key command in upper case with a pressed state
        add_text("[K,7,D");
        add_row(OP_BYTE, CH_RBRACKET, 1'b1, key_rec);
        // joystick with a negative value and one that wraps past 16 bits
        add_text("[j,-1,70000,0,4]");
        // zero byte inside an open frame, then a disconnect mid-frame
        add_text("[s");
        add_row(OP_BYTE, CH_NUL, 1'b0, '0);
        add_row(OP_DISCONNECT, 8'h00, 1'b1, cleared_rec);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].op, directed_rows[r].data, directed_rows[r].typed,
                      directed_rows[r].want, 1'b0);

        items_taken  = 0;
        frames_built = 0;
        while (items_taken < RANDOM_ITEMS || records_predicted < MIN_RECORDS) begin
            frames_built++;
            build_traffic(frames_built == OVERSIZE_FRAME || $urandom_range(0, 99) == 0);
            send_burst($urandom_range(0, 9) < 3);
        end
        i_s_tvalid <= 1'b0;

        // drain: wait for every predicted record, then watch for strays
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("bracketed_command_parser test passed");
        end else begin
            $display("bracketed_command_parser test failed");
        end
        $finish;
    end

endmodule
